// ===== sv/fcsg_pkg.sv =====
// ---------------------------------------------------------------------------
// fcsg_pkg
// Shared types and codes for the filled circle span generator.
// ---------------------------------------------------------------------------
package fcsg_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam int SPAN_CNT_BITS = 2;

    typedef enum logic [SPAN_CNT_BITS-1:0] {
        SPAN_TOP_ROW    = 2'd0,
        SPAN_BOTTOM_ROW = 2'd1,
        SPAN_UPPER_MID  = 2'd2,
        SPAN_LOWER_MID  = 2'd3
    } span_sel_t;

    typedef struct packed {
        logic start;
        logic done;
    } step_ctl_t;

endpackage

// ===== sv/fcsg_octant.sv =====
// ---------------------------------------------------------------------------
// fcsg_octant
// Octant point, decision state; advances once per accepted step when active.
// ---------------------------------------------------------------------------
module fcsg_octant #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          kind,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        radius,
    output logic [COORD_BITS-1:0]         cx,
    output logic [COORD_BITS-1:0]         cy,
    output logic signed [RADIUS_BITS:0]   px,
    output logic signed [RADIUS_BITS:0]   py,
    output fcsg_pkg::step_ctl_t           ctl
);
    import fcsg_pkg::*;

    localparam int PT_BITS  = RADIUS_BITS + 1;
    localparam int DEC_BITS = RADIUS_BITS + 4;

    logic [COORD_BITS-1:0]      cx_reg;
    logic [COORD_BITS-1:0]      cy_reg;
    logic signed [PT_BITS-1:0]  x_reg, x_next;
    logic signed [PT_BITS-1:0]  y_reg, y_next;
    logic signed [DEC_BITS-1:0] d_reg, d_next;
    logic                       active_reg;

    logic signed [DEC_BITS-1:0] x_ext, y_ext, r_ext;
    logic                       start;
    logic                       done;
    logic                       load;

    assign x_ext = {{(DEC_BITS-PT_BITS){x_reg[PT_BITS-1]}}, x_reg};
    assign y_ext = {{(DEC_BITS-PT_BITS){y_reg[PT_BITS-1]}}, y_reg};
    assign r_ext = {{(DEC_BITS-RADIUS_BITS){1'b0}}, radius};

    assign load  = accept && (kind == KIND_LOAD);
    assign start = accept && (kind == KIND_STEP) && active_reg;

    always_comb
    begin
        if (d_reg[DEC_BITS-1])
        begin
            d_next = d_reg + (x_ext <<< 2) + DEC_BITS'(6);
            y_next = y_reg;
        end
        else
        begin
            d_next = d_reg + ((x_ext - y_ext) <<< 2) + DEC_BITS'(10);
            y_next = y_reg - PT_BITS'(1);
        end
        x_next = x_reg + PT_BITS'(1);
        done   = (y_next < x_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            active_reg <= 1'b0;
        end
        else if (load)
        begin
            cx_reg     <= center_x;
            cy_reg     <= center_y;
            x_reg      <= '0;
            y_reg      <= {1'b0, radius};
            d_reg      <= DEC_BITS'(3) - (r_ext <<< 1);
            active_reg <= 1'b1;
        end
        else if (start)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            d_reg <= d_next;
            if (done)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign px        = x_reg;
    assign py        = y_reg;
    assign ctl.start = start;
    assign ctl.done  = done;

endmodule

// ===== sv/fcsg_emit.sv =====
// ---------------------------------------------------------------------------
// fcsg_emit
// Holds one octant point and sends its four spans, one beat at a time.
// ---------------------------------------------------------------------------
module fcsg_emit #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcsg_pkg::step_ctl_t           ctl,
    input  logic [COORD_BITS-1:0]         cx,
    input  logic [COORD_BITS-1:0]         cy,
    input  logic signed [RADIUS_BITS:0]   px,
    input  logic signed [RADIUS_BITS:0]   py,
    output logic                          free,
    output logic                          span_valid,
    input  logic                          span_stall,
    output logic signed [COORD_BITS+1:0]  span_row,
    output logic signed [COORD_BITS+1:0]  span_left,
    output logic signed [COORD_BITS+1:0]  span_right,
    output logic                          last_of_step,
    output logic                          circle_done
);
    import fcsg_pkg::*;

    localparam int PT_BITS  = RADIUS_BITS + 1;
    localparam int OUT_BITS = COORD_BITS + 2;
    localparam int W = ((OUT_BITS > PT_BITS) ? OUT_BITS : PT_BITS) + 1;

    logic [COORD_BITS-1:0]     cx_reg;
    logic [COORD_BITS-1:0]     cy_reg;
    logic signed [PT_BITS-1:0] x_reg;
    logic signed [PT_BITS-1:0] y_reg;
    logic                      done_reg;
    logic                      busy_reg;
    span_sel_t                 sel_reg;

    logic signed [W-1:0] cxw, cyw, xw, yw;
    logic signed [W-1:0] row_w, left_w, right_w;
    logic                beat;

    assign beat = busy_reg && !span_stall;
    assign free = !busy_reg || (beat && (sel_reg == SPAN_LOWER_MID));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= SPAN_TOP_ROW;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            sel_reg  <= SPAN_TOP_ROW;
        end
        else if (beat)
        begin
            if (sel_reg == SPAN_LOWER_MID)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                sel_reg <= span_sel_t'(sel_reg + SPAN_CNT_BITS'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cx_reg   <= cx;
            cy_reg   <= cy;
            x_reg    <= px;
            y_reg    <= py;
            done_reg <= ctl.done;
        end
    end

    assign cxw = $signed({{(W-COORD_BITS){1'b0}}, cx_reg});
    assign cyw = $signed({{(W-COORD_BITS){1'b0}}, cy_reg});
    assign xw  = {{(W-PT_BITS){x_reg[PT_BITS-1]}}, x_reg};
    assign yw  = {{(W-PT_BITS){y_reg[PT_BITS-1]}}, y_reg};

    always_comb
    begin
        case (sel_reg)
            SPAN_TOP_ROW:
            begin
                row_w   = cyw - yw;
                left_w  = cxw - xw;
                right_w = cxw + xw;
            end
            SPAN_BOTTOM_ROW:
            begin
                row_w   = cyw + yw;
                left_w  = cxw - xw;
                right_w = cxw + xw;
            end
            SPAN_UPPER_MID:
            begin
                row_w   = cyw - xw;
                left_w  = cxw - yw;
                right_w = cxw + yw;
            end
            SPAN_LOWER_MID:
            begin
                row_w   = cyw + xw;
                left_w  = cxw - yw;
                right_w = cxw + yw;
            end
            default:
            begin
                row_w   = '0;
                left_w  = '0;
                right_w = '0;
            end
        endcase
    end

    assign span_valid   = busy_reg;
    assign span_row     = row_w[OUT_BITS-1:0];
    assign span_left    = left_w[OUT_BITS-1:0];
    assign span_right   = right_w[OUT_BITS-1:0];
    assign last_of_step = (sel_reg == SPAN_LOWER_MID);
    assign circle_done  = (sel_reg == SPAN_LOWER_MID) && done_reg;

endmodule

// ===== sv/filled_circle_span_generator_top.sv =====
// ---------------------------------------------------------------------------
// filled_circle_span_generator_top
// Midpoint filled circle rasterizer: a load beat sets center and radius, each
// step beat of an active circle yields the four horizontal spans of one point.
//
//   channel | valid      | stall      | payload
//   item    | item_valid | item_stall | kind, center_x, center_y, radius
//   span    | span_valid | span_stall | span_row, span_left, span_right,
//           |            |            | last_of_step, circle_done
//
// a step beat is followed by its four span beats on one output port
// a load beat or a step while idle gives no span
// the first span shows the cycle after the step beat is taken
// item_stall is high while spans are pending, low in the cycle the last goes
// reset clears the circle state to idle and drops any pending spans
// ---------------------------------------------------------------------------
module filled_circle_span_generator_top #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          kind,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        radius,
    output logic                          span_valid,
    input  logic                          span_stall,
    output logic signed [COORD_BITS+1:0]  span_row,
    output logic signed [COORD_BITS+1:0]  span_left,
    output logic signed [COORD_BITS+1:0]  span_right,
    output logic                          last_of_step,
    output logic                          circle_done
);
    import fcsg_pkg::*;

    logic                        accept;
    logic                        free;
    logic [COORD_BITS-1:0]       cx, cy;
    logic signed [RADIUS_BITS:0] px, py;
    step_ctl_t                   ctl;

    assign item_stall = !free;
    assign accept     = item_valid && free;

    fcsg_octant #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_octant (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (kind),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .cx       (cx),
        .cy       (cy),
        .px       (px),
        .py       (py),
        .ctl      (ctl)
    );

    fcsg_emit #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cx           (cx),
        .cy           (cy),
        .px           (px),
        .py           (py),
        .free         (free),
        .span_valid   (span_valid),
        .span_stall   (span_stall),
        .span_row     (span_row),
        .span_left    (span_left),
        .span_right   (span_right),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Testbench for the filled circle span generator. A midpoint circle predictor
// tracks every accepted load and step beat and queues the four spans each
// step should give; every span beat taken from the block is checked against
// the oldest queued span, field by field. A short directed opening covers
// idle steps, zero radius, center and radius extremes and an abandoned
// circle. Random circles follow, mostly small ones run to the end, with some
// large or cut-short circles and stray steps, under random gaps and stalls.
// ---------------------------------------------------------------------------
module tb;
    import fcsg_pkg::*;

    localparam int COORD_BITS  = 11;
    localparam int RADIUS_BITS = 10;
    localparam int OUT_BITS    = COORD_BITS + 2;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] row;
        logic signed [OUT_BITS-1:0] left;
        logic signed [OUT_BITS-1:0] right;
        logic                       last;
        logic                       done;
    } span_t;

    class span_scoreboard;
        logic [COORD_BITS-1:0]  center_col;
        logic [COORD_BITS-1:0]  center_row;
        logic [RADIUS_BITS-1:0] octant_x;
        logic [RADIUS_BITS-1:0] octant_y;
        logic signed [13:0]     decision;
        bit                     drawing;
        span_t                  spans_due[$];
        int                     errors;
        int                     spans_seen;
        int                     loads;
        int                     steps;
        int                     circles_done;

        function void push_span(int row, int left, int right, bit last, bit done);
            span_t s;
            s.row   = OUT_BITS'(row);
            s.left  = OUT_BITS'(left);
            s.right = OUT_BITS'(right);
            s.last  = last;
            s.done  = done;
            spans_due.push_back(s);
        endfunction

        function void note_item(logic k, logic [COORD_BITS-1:0] cx,
                                logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] r);
            int x;
            int y;
            int d;
            int nx;
            int ny;
            int nd;
            int ccol;
            int crow;
            bit fin;
            if (k == KIND_LOAD)
            begin
                center_col = cx;
                center_row = cy;
                octant_x   = '0;
                octant_y   = r;
                decision   = 14'(3 - 2 * int'(r));
                drawing    = 1'b1;
                loads++;
                return;
            end
            if (!drawing)
                return;
            ccol = int'(center_col);
            crow = int'(center_row);
            x    = int'(octant_x);
            y    = int'(octant_y);
            d    = int'(decision);
            nx   = x + 1;
            ny   = y;
            if (d < 0)
            begin
                nd = d + 4 * x + 6;
            end
            else
            begin
                nd = d + 4 * (x - y) + 10;
                ny = y - 1;
            end
            fin = (ny < nx);
            push_span(crow - y, ccol - x, ccol + x, 1'b0, 1'b0);
            push_span(crow + y, ccol - x, ccol + x, 1'b0, 1'b0);
            push_span(crow - x, ccol - y, ccol + y, 1'b0, 1'b0);
            push_span(crow + x, ccol - y, ccol + y, 1'b1, fin);
            octant_x = RADIUS_BITS'(nx);
            octant_y = RADIUS_BITS'(ny);
            decision = 14'(nd);
            steps++;
            if (fin)
            begin
                drawing = 1'b0;
                circles_done++;
            end
        endfunction

        function void check_span(logic signed [OUT_BITS-1:0] row,
                                 logic signed [OUT_BITS-1:0] left,
                                 logic signed [OUT_BITS-1:0] right,
                                 logic last, logic done);
            span_t e;
            spans_seen++;
            if (spans_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected span row %0d left %0d right %0d last %0b done %0b",
                         $time, row, left, right, last, done);
                return;
            end
            e = spans_due.pop_front();
            if (row !== e.row)
            begin
                errors++;
                $display("%0t: span_row expected %0d got %0d", $time, e.row, row);
            end
            if (left !== e.left)
            begin
                errors++;
                $display("%0t: span_left expected %0d got %0d", $time, e.left, left);
            end
            if (right !== e.right)
            begin
                errors++;
                $display("%0t: span_right expected %0d got %0d", $time, e.right, right);
            end
            if (last !== e.last)
            begin
                errors++;
                $display("%0t: last_of_step expected %0b got %0b", $time, e.last, last);
            end
            if (done !== e.done)
            begin
                errors++;
                $display("%0t: circle_done expected %0b got %0b", $time, e.done, done);
            end
        endfunction

        function int pending();
            return spans_due.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          item_valid = 1'b0;
    logic                          item_stall;
    logic                          kind = KIND_LOAD;
    logic [COORD_BITS-1:0]         center_x = '0;
    logic [COORD_BITS-1:0]         center_y = '0;
    logic [RADIUS_BITS-1:0]        radius = '0;
    logic                          span_valid;
    logic                          span_stall = 1'b0;
    logic signed [OUT_BITS-1:0]    span_row;
    logic signed [OUT_BITS-1:0]    span_left;
    logic signed [OUT_BITS-1:0]    span_right;
    logic                          last_of_step;
    logic                          circle_done;

    span_scoreboard sb = new();
    int items_sent;
    int calm_left;

    filled_circle_span_generator_top #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .span_valid   (span_valid),
        .span_stall   (span_stall),
        .span_row     (span_row),
        .span_left    (span_left),
        .span_right   (span_right),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(kind, center_x, center_y, radius);
        if (rst_n && span_valid && !span_stall)
            sb.check_span(span_row, span_left, span_right, last_of_step, circle_done);
    end

    // receiver side: flowing stretches, short stalls, now and then a long one
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(10, 60);
            else
                n = $urandom_range(1, 4);
            repeat (n)
            begin
                @(negedge clk);
                span_stall <= 1'b0;
            end
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            repeat (n)
            begin
                @(negedge clk);
                span_stall <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int p;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 8)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // called and returns at a falling edge
    task automatic send_item(logic k, logic [COORD_BITS-1:0] cx,
                             logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] r);
        int gap;
        gap = pick_gap();
        if (!(k == KIND_STEP && !sb.drawing))
            items_sent++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            kind       <= 1'($urandom_range(0, 1));
            center_x   <= COORD_BITS'($urandom_range(0, 2047));
            center_y   <= COORD_BITS'($urandom_range(0, 2047));
            radius     <= RADIUS_BITS'($urandom_range(0, 1023));
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        center_x   <= cx;
        center_y   <= cy;
        radius     <= r;
        do @(posedge clk); while (item_stall);
        @(negedge clk);
    endtask

    task automatic step_once();
        send_item(KIND_STEP, COORD_BITS'($urandom_range(0, 2047)),
                  COORD_BITS'($urandom_range(0, 2047)),
                  RADIUS_BITS'($urandom_range(0, 1023)));
    endtask

    task automatic run_circle(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                              logic [RADIUS_BITS-1:0] r);
        send_item(KIND_LOAD, cx, cy, r);
        while (sb.drawing)
            step_once();
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        int p;
        bit drained;
        drained = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening
        step_once();
        run_circle(11'd0, 11'd0, 10'd0);
        step_once();
        send_item(KIND_LOAD, 11'd2047, 11'd2047, 10'd1023);
        repeat (3) step_once();
        send_item(KIND_LOAD, 11'd0, 11'd0, 10'd1023);
        repeat (2) step_once();
        run_circle(11'd1024, 11'd1000, 10'd1);
        run_circle(11'd5, 11'd5, 10'd2);
        step_once();
        run_circle(11'd2047, 11'd0, 10'd3);

        // random circles and noise
        while (items_sent < 350)
        begin
            if (!drained && items_sent >= 175)
            begin
                drain();
                drained = 1'b1;
            end
            p = $urandom_range(0, 99);
            if (p < 68)
            begin
                run_circle(COORD_BITS'($urandom_range(0, 2047)),
                           COORD_BITS'($urandom_range(0, 2047)),
                           RADIUS_BITS'($urandom_range(0, 30)));
            end
            else if (p < 72)
            begin
                run_circle(COORD_BITS'($urandom_range(0, 2047)),
                           COORD_BITS'($urandom_range(0, 2047)),
                           RADIUS_BITS'($urandom_range(40, 120)));
            end
            else if (p < 82)
            begin
                send_item(KIND_LOAD, COORD_BITS'($urandom_range(0, 2047)),
                          COORD_BITS'($urandom_range(0, 2047)),
                          RADIUS_BITS'($urandom_range(0, 1023)));
                repeat ($urandom_range(1, 12)) step_once();
            end
            else if (p < 92)
            begin
                repeat ($urandom_range(1, 3)) step_once();
            end
            else
            begin
                send_item(KIND_LOAD, COORD_BITS'($urandom_range(0, 2047)),
                          COORD_BITS'($urandom_range(0, 2047)),
                          RADIUS_BITS'($urandom_range(0, 63)));
                repeat ($urandom_range(0, 4)) step_once();
                if ($urandom_range(0, 3) == 0)
                    drain();
            end
        end

        item_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d circle loads, %0d steps, %0d finished circles",
                 sb.loads, sb.steps, sb.circles_done);
        $display("checked %0d span beats, %0d mismatches", sb.spans_seen, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("timeout with %0d spans still due", sb.pending());
        $display("tb NOT OK");
        $finish;
    end

endmodule
